// ===== hw/rtl/rsd_pkg.sv =====
// rsd_pkg: shared types and GF(16) arithmetic for the RS(15,8) decoder
// field polynomial x^4+x+1, alpha = 2; no dependencies
package rsd_pkg;

  localparam int unsigned SymW   = 4;
  localparam int unsigned NumSym = 15;
  localparam int unsigned NumSyn = 7;
  localparam int unsigned WordW  = SymW * NumSym;

  typedef logic [SymW-1:0] sym_t;
  typedef logic [NumSyn-1:0][SymW-1:0] syn_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    syn_t             syn;
    logic             clean;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  function automatic sym_t gf_exp(input logic [3:0] k);
    sym_t r;
    case (k)
      4'd0:    r = 4'd1;
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd8;
      4'd4:    r = 4'd3;
      4'd5:    r = 4'd6;
      4'd6:    r = 4'd12;
      4'd7:    r = 4'd11;
      4'd8:    r = 4'd5;
      4'd9:    r = 4'd10;
      4'd10:   r = 4'd7;
      4'd11:   r = 4'd14;
      4'd12:   r = 4'd15;
      4'd13:   r = 4'd13;
      4'd14:   r = 4'd9;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] gf_log(input sym_t a);
    logic [3:0] r;
    case (a)
      4'd1:    r = 4'd0;
      4'd2:    r = 4'd1;
      4'd3:    r = 4'd4;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd8;
      4'd6:    r = 4'd5;
      4'd7:    r = 4'd10;
      4'd8:    r = 4'd3;
      4'd9:    r = 4'd14;
      4'd10:   r = 4'd9;
      4'd11:   r = 4'd7;
      4'd12:   r = 4'd6;
      4'd13:   r = 4'd13;
      4'd14:   r = 4'd11;
      4'd15:   r = 4'd12;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic sym_t gf_mul(input sym_t a, input sym_t b);
    logic [4:0] s;
    sym_t       r;
    s = {1'b0, gf_log(a)} + {1'b0, gf_log(b)};
    if (s >= 5'd15) begin
      s = s - 5'd15;
    end
    r = gf_exp(s[3:0]);
    if (a == '0 || b == '0) begin
      r = '0;
    end
    return r;
  endfunction

  function automatic sym_t gf_inv(input sym_t a);
    logic [3:0] l;
    sym_t       r;
    l = gf_log(a);
    r = (l == 4'd0) ? 4'd1 : gf_exp(4'd15 - l);
    if (a == '0) begin
      r = '0;
    end
    return r;
  endfunction

  // s[m-1] = r(alpha^m), m = 1..7
  function automatic syn_t syndromes(input logic [WordW-1:0] w);
    syn_t       s;
    sym_t       acc;
    logic [4:0] e;
    for (int m = 1; m <= NumSyn; m++) begin
      acc = '0;
      e   = '0;
      for (int i = 0; i < NumSym; i++) begin
        acc = acc ^ gf_mul(w[SymW*i +: SymW], gf_exp(e[3:0]));
        e = e + 5'(m);
        if (e >= 5'd15) begin
          e = e - 5'd15;
        end
      end
      s[m-1] = acc;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/rsd_in_if.sv =====
// rsd_in_if: received word channel, valid/ready with payload
// depends on rsd_pkg
interface rsd_in_if import rsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] received_word;

  modport source (output valid, output received_word, input ready);
  modport sink   (input valid, input received_word, output ready);
endinterface

// ===== hw/rtl/rsd_out_if.sv =====
// rsd_out_if: decoded word channel, valid/ready with payload
// depends on rsd_pkg
interface rsd_out_if import rsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] corrected_word;
  logic             decode_ok;

  modport source (output valid, output corrected_word, output decode_ok, input ready);
  modport sink   (input valid, input corrected_word, input decode_ok, output ready);
endinterface

// ===== hw/rtl/rsd_front.sv =====
// rsd_front: accepts words, computes syndromes, flags clean words, queues them
// depends on rsd_pkg and rsd_in_if
module rsd_front import rsd_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsd_in_if.sink    in_i,
  input  logic      pop_i,
  output q_head_t   head_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  q_entry_t            mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push;
  logic                pop;
  q_entry_t            new_entry;

  assign in_i.ready = (cnt_q != CntW'(QDepth));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = pop_i && (cnt_q != '0);

  always_comb begin
    new_entry.word  = in_i.received_word;
    new_entry.syn   = syndromes(in_i.received_word);
    new_entry.clean = (new_entry.syn == '0);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule

// ===== hw/rtl/rsd_back.sv =====
// rsd_back: berlekamp-massey, chien search with forney values, final check
// depends on rsd_pkg and rsd_out_if
module rsd_back import rsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_head_t   head_i,
  output logic      pop_o,
  rsd_out_if.source out_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StBm     = 3'd1;
  localparam logic [2:0] StOmega  = 3'd2;
  localparam logic [2:0] StChien  = 3'd3;
  localparam logic [2:0] StVerify = 3'd4;
  localparam logic [3:0] LastBm   = 4'd5;
  localparam logic [3:0] LastSym  = 4'd14;

  logic [2:0]       state_q, state_d;
  logic [3:0]       step_q, step_d;
  logic [WordW-1:0] rx_q, word_q;
  syn_t             syn_q;
  sym_t             lam_q [4];
  sym_t             b_q [4];
  sym_t             gam_q;
  logic [2:0]       len_q;
  sym_t             lt_q [4];
  sym_t             ot_q [3];
  sym_t             v_q;
  logic             out_vld_q;
  logic [WordW-1:0] out_word_q;
  logic             out_ok_q;

  sym_t disc;
  sym_t lam_n [4];
  sym_t om [3];
  sym_t ev, odd, om_v, err;
  logic slot_free;
  logic ok;

  assign slot_free = !out_vld_q || out_o.ready;
  assign pop_o     = (state_q == StIdle) && head_i.valid;
  assign ok        = (syndromes(word_q) == '0);

  always_comb begin
    disc = '0;
    for (int j = 0; j < 4; j++) begin
      if (j <= int'(step_q)) begin
        disc = disc ^ gf_mul(lam_q[j], syn_q[step_q[2:0] - 3'(j)]);
      end
    end
    for (int j = 0; j < 4; j++) begin
      lam_n[j] = gf_mul(gam_q, lam_q[j]) ^ ((j == 0) ? '0 : gf_mul(disc, b_q[(j+3)%4]));
    end
    for (int k = 0; k < 3; k++) begin
      om[k] = '0;
      for (int j = 0; j <= k; j++) begin
        om[k] = om[k] ^ gf_mul(lam_q[j], syn_q[k-j]);
      end
    end
    ev   = lt_q[0] ^ lt_q[1] ^ lt_q[2] ^ lt_q[3];
    odd  = lt_q[1] ^ lt_q[3];
    om_v = ot_q[0] ^ ot_q[1] ^ ot_q[2];
    err  = gf_mul(gf_mul(om_v, v_q), gf_inv(odd));
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          state_d = head_i.entry.clean ? StVerify : StBm;
          step_d  = '0;
        end
      end
      StBm: begin
        step_d = step_q + 1'b1;
        if (step_q == LastBm) begin
          state_d = StOmega;
        end
      end
      StOmega: begin
        state_d = StChien;
        step_d  = '0;
      end
      StChien: begin
        step_d = step_q + 1'b1;
        if (step_q == LastSym) begin
          state_d = StVerify;
        end
      end
      StVerify: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == StVerify && slot_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        rx_q   <= head_i.entry.word;
        word_q <= head_i.entry.word;
        syn_q  <= head_i.entry.syn;
        gam_q  <= 4'd1;
        len_q  <= '0;
        for (int j = 0; j < 4; j++) begin
          lam_q[j] <= (j == 0) ? 4'd1 : 4'd0;
          b_q[j]   <= (j == 0) ? 4'd1 : 4'd0;
        end
      end
      StBm: begin
        for (int j = 0; j < 4; j++) begin
          lam_q[j] <= lam_n[j];
        end
        if (disc != '0 && {len_q, 1'b0} <= {1'b0, step_q[2:0]}) begin
          for (int j = 0; j < 4; j++) begin
            b_q[j] <= lam_q[j];
          end
          len_q <= step_q[2:0] + 3'd1 - len_q;
          gam_q <= disc;
        end else begin
          b_q[0] <= '0;
          for (int j = 1; j < 4; j++) begin
            b_q[j] <= b_q[j-1];
          end
        end
      end
      StOmega: begin
        for (int j = 0; j < 4; j++) begin
          lt_q[j] <= lam_q[j];
        end
        for (int k = 0; k < 3; k++) begin
          ot_q[k] <= om[k];
        end
        v_q <= 4'd1;
      end
      StChien: begin
        if (ev == '0) begin
          word_q[SymW*step_q +: SymW] <= word_q[SymW*step_q +: SymW] ^ err;
        end
        // step to the next position: multiply term j by alpha^-j
        lt_q[1] <= gf_mul(lt_q[1], gf_exp(4'd14));
        lt_q[2] <= gf_mul(lt_q[2], gf_exp(4'd13));
        lt_q[3] <= gf_mul(lt_q[3], gf_exp(4'd12));
        ot_q[1] <= gf_mul(ot_q[1], gf_exp(4'd14));
        ot_q[2] <= gf_mul(ot_q[2], gf_exp(4'd13));
        v_q     <= gf_mul(v_q, gf_exp(4'd14));
      end
      StVerify: begin
        if (slot_free) begin
          out_word_q <= ok ? word_q : rx_q;
          out_ok_q   <= ok;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.corrected_word = out_word_q;
  assign out_o.decode_ok      = out_ok_q;

endmodule

// ===== hw/rtl/rs15_8_gf16_decoder.sv =====
// rs15_8_gf16_decoder: top level of the RS(15,8) GF(16) decoder
// depends on rsd_pkg, rsd_in_if, rsd_out_if, rsd_front, rsd_back
//
//  channel | dir | payload
//  in_i    | in  | received_word[59:0]
//  out_o   | out | corrected_word[59:0], decode_ok
//
// a word with all syndromes zero is loaded and goes straight to the check in the back end;
// any other word is loaded, then takes 6 berlekamp-massey steps, an omega step, 15 chien
// steps (one symbol per cycle) and the check; the back end is the limit
// the front takes a beat per cycle while the queue has room
// reset clears the queue and the back end; no clearing pass
module rs15_8_gf16_decoder import rsd_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsd_in_if.sink    in_i,
  rsd_out_if.source out_o
);

  q_head_t head;
  logic    pop;

  rsd_front #(.QDepth(QDepth)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .head_o (head)
  );

  rsd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid) else $error("pop from empty queue");
  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head.valid && !pop && !(in_i.valid && in_i.ready) |=> head.valid && $stable(head.entry))
    else $error("queue head changed without pop");
  a_fail_keeps_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) && !out_o.decode_ok |-> out_o.corrected_word != 60'd0)
    else $error("zero word reported uncorrectable");
`endif

endmodule
